// ===== hw/rtl/pdtc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdtc_pkg
// shared types and constants of the decision tree packet classifier
// ----------------------------------------------------------------------------
package pdtc_pkg;

  // default sizes
  localparam int NodeDepthDef    = 4096;
  localparam int RuleDepthDef    = 4096;
  localparam int MaxTreesDef     = 16;
  localparam int MaxWalkDepthDef = 16;

  // queue between front and engine
  localparam int QueueDepth = 2;

  // input function codes
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_NODE   = 2'd1;
  localparam logic [1:0] FUNC_RULE   = 2'd2;
  localparam logic [1:0] FUNC_ROOT   = 2'd3;

  // node word selects
  localparam logic [1:0] NSEL_MASK = 2'd0;
  localparam logic [1:0] NSEL_INFO = 2'd1;

  // rule word selects
  localparam logic [1:0] RSEL_SRC   = 2'd0;
  localparam logic [1:0] RSEL_DST   = 2'd1;
  localparam logic [1:0] RSEL_PORT  = 2'd2;
  localparam logic [1:0] RSEL_PPRIO = 2'd3;

  // node kinds
  localparam logic [1:0] KIND_LEAF     = 2'd0;
  localparam logic [1:0] KIND_ADDR_CUT = 2'd1;
  localparam logic [1:0] KIND_PORT_CUT = 2'd2;

  // extract steps (four bits each) for the three kinds of pass
  localparam logic [4:0] STEPS_BASE = 5'd3;
  localparam logic [4:0] STEPS_ADDR = 5'd16;
  localparam logic [4:0] STEPS_PORT = 5'd4;
  localparam logic [4:0] STEPS_NONE = 5'd0;

  // decoded operations
  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_NODE_MASK,
    OP_NODE_INFO,
    OP_RULE_SRC,
    OP_RULE_DST,
    OP_RULE_PORT,
    OP_RULE_PPRIO,
    OP_ROOT
  } op_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] index;
    logic [1:0]  word_sel;
    logic [63:0] write_data;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic [15:0] floor_priority;
  } in_item_t;

  typedef struct packed {
    logic [15:0] best_priority;
    logic        walk_aborted;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] index;
    logic [63:0] data;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic [15:0] floor_priority;
  } cmd_t;

  // request to the extract and modulo unit
  typedef struct packed {
    logic        start;
    logic [11:0] base;
    logic [63:0] value;
    logic [63:0] mask;
    logic [4:0]  steps;
  } ext_req_t;

endpackage

// ===== hw/rtl/pdtc_ram.sv =====
// ----------------------------------------------------------------------------
// pdtc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pdtc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pdtc_front.sv =====
// ----------------------------------------------------------------------------
// pdtc_front
// accepts input transactions, decodes them and drops writes that hit nothing
// ----------------------------------------------------------------------------
module pdtc_front #(
  parameter int NODE_DEPTH = pdtc_pkg::NodeDepthDef,
  parameter int RULE_DEPTH = pdtc_pkg::RuleDepthDef,
  parameter int MAX_TREES  = pdtc_pkg::MaxTreesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pdtc_pkg::in_item_t in_data,
  output logic               push,
  input  logic               push_ready,
  output pdtc_pkg::cmd_t     push_data
);

  logic           v_r;
  pdtc_pkg::cmd_t cmd_r;
  pdtc_pkg::cmd_t cmd_nxt;
  logic           keep;
  logic           accept;

  assign in_ready  = !v_r || push_ready;
  assign accept    = in_valid && in_ready;
  assign push      = v_r;
  assign push_data = cmd_r;

  // decode function and word select, check slot range
  always_comb begin
    cmd_nxt.index          = in_data.index;
    cmd_nxt.data           = in_data.write_data;
    cmd_nxt.src_ip         = in_data.src_ip;
    cmd_nxt.dst_ip         = in_data.dst_ip;
    cmd_nxt.src_port       = in_data.src_port;
    cmd_nxt.dst_port       = in_data.dst_port;
    cmd_nxt.protocol       = in_data.protocol;
    cmd_nxt.floor_priority = in_data.floor_priority;
    cmd_nxt.op             = pdtc_pkg::OP_LOOKUP;
    keep                   = 1'b1;
    unique case (in_data.func)
      pdtc_pkg::FUNC_LOOKUP: begin
        cmd_nxt.op = pdtc_pkg::OP_LOOKUP;
      end
      pdtc_pkg::FUNC_NODE: begin
        keep = (32'(in_data.index) < NODE_DEPTH);
        case (in_data.word_sel)
          pdtc_pkg::NSEL_MASK: cmd_nxt.op = pdtc_pkg::OP_NODE_MASK;
          pdtc_pkg::NSEL_INFO: cmd_nxt.op = pdtc_pkg::OP_NODE_INFO;
          default:             keep = 1'b0;
        endcase
      end
      pdtc_pkg::FUNC_RULE: begin
        keep = (32'(in_data.index) < RULE_DEPTH);
        unique case (in_data.word_sel)
          pdtc_pkg::RSEL_SRC:   cmd_nxt.op = pdtc_pkg::OP_RULE_SRC;
          pdtc_pkg::RSEL_DST:   cmd_nxt.op = pdtc_pkg::OP_RULE_DST;
          pdtc_pkg::RSEL_PORT:  cmd_nxt.op = pdtc_pkg::OP_RULE_PORT;
          pdtc_pkg::RSEL_PPRIO: cmd_nxt.op = pdtc_pkg::OP_RULE_PPRIO;
          default:              keep = 1'b0;
        endcase
      end
      pdtc_pkg::FUNC_ROOT: begin
        keep       = (32'(in_data.index) < MAX_TREES);
        cmd_nxt.op = pdtc_pkg::OP_ROOT;
      end
      default: keep = 1'b0;
    endcase
  end

  // holding register in front of the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= keep;
    end else if (push_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== hw/rtl/pdtc_queue.sv =====
// ----------------------------------------------------------------------------
// pdtc_queue
// short command queue between the front and the engine
// ----------------------------------------------------------------------------
module pdtc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           push_ready,
  input  pdtc_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output pdtc_pkg::cmd_t pop_data
);

  localparam int PW = (pdtc_pkg::QueueDepth > 1) ? $clog2(pdtc_pkg::QueueDepth) : 1;
  localparam int CW = $clog2(pdtc_pkg::QueueDepth + 1);

  pdtc_pkg::cmd_t mem_r [pdtc_pkg::QueueDepth];
  logic [PW-1:0]  wp_r;
  logic [PW-1:0]  rp_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (cnt_r != CW'(pdtc_pkg::QueueDepth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(pdtc_pkg::QueueDepth - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(pdtc_pkg::QueueDepth - 1)) ? '0 : rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/pdtc_extract.sv =====
// ----------------------------------------------------------------------------
// pdtc_extract
// serial bit extract with modulo reduction, four bits per cycle
// ----------------------------------------------------------------------------
module pdtc_extract #(
  parameter int MOD = pdtc_pkg::NodeDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pdtc_pkg::ext_req_t req,
  output logic               done,
  output logic [$clog2(MOD)-1:0] result
);

  localparam int AW = $clog2(MOD);

  logic          busy_r;
  logic          phase_r;
  logic          done_r;
  logic [63:0]   sv_r;
  logic [63:0]   sm_r;
  logic [4:0]    left_r;
  logic [AW-1:0] key_r;
  logic [AW-1:0] pow_r;
  logic [63:0]   xv_r;
  logic [63:0]   xm_r;
  logic [4:0]    xs_r;
  logic [AW-1:0] key_nxt;
  logic [AW-1:0] pow_nxt;
  logic [AW:0]   acc;
  logic [AW:0]   dbl;

  assign done   = done_r;
  assign result = key_r;

  // four selected-bit steps: key += bit * pow, pow doubles per selected bit
  always_comb begin
    key_nxt = key_r;
    pow_nxt = pow_r;
    acc     = '0;
    dbl     = '0;
    for (int i = 0; i < 4; i++) begin
      if (sm_r[i]) begin
        if (sv_r[i]) begin
          acc = {1'b0, key_nxt} + {1'b0, pow_nxt};
          key_nxt = (acc >= (AW+1)'(MOD)) ? AW'(acc - (AW+1)'(MOD)) : AW'(acc);
        end
        dbl = {pow_nxt, 1'b0};
        pow_nxt = (dbl >= (AW+1)'(MOD)) ? AW'(dbl - (AW+1)'(MOD)) : AW'(dbl);
      end
    end
  end

  // control of the base pass and the extract pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && left_r == 5'd1 && (phase_r || xs_r == pdtc_pkg::STEPS_NONE)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      phase_r <= 1'b0;
      sv_r    <= 64'(req.base);
      sm_r    <= 64'hFFF;
      left_r  <= pdtc_pkg::STEPS_BASE;
      key_r   <= '0;
      pow_r   <= AW'(1);
      xv_r    <= req.value;
      xm_r    <= req.mask;
      xs_r    <= req.steps;
    end else if (busy_r) begin
      key_r <= key_nxt;
      if (left_r == 5'd1 && !phase_r && xs_r != pdtc_pkg::STEPS_NONE) begin
        phase_r <= 1'b1;
        sv_r    <= xv_r;
        sm_r    <= xm_r;
        left_r  <= xs_r;
        pow_r   <= AW'(1);
      end else begin
        sv_r   <= sv_r >> 4;
        sm_r   <= sm_r >> 4;
        left_r <= left_r - 5'd1;
        pow_r  <= pow_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/pdtc_engine.sv =====
// ----------------------------------------------------------------------------
// pdtc_engine
// carries out writes and tree walks over the node, rule and root memories
// ----------------------------------------------------------------------------
module pdtc_engine #(
  parameter int NODE_DEPTH     = pdtc_pkg::NodeDepthDef,
  parameter int RULE_DEPTH     = pdtc_pkg::RuleDepthDef,
  parameter int MAX_TREES      = pdtc_pkg::MaxTreesDef,
  parameter int MAX_WALK_DEPTH = pdtc_pkg::MaxWalkDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  pdtc_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output pdtc_pkg::out_item_t out_data
);

  localparam int AWN = $clog2(NODE_DEPTH);
  localparam int AWR = $clog2(RULE_DEPTH);
  localparam int TW  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int CW  = $clog2(MAX_TREES + 1);
  localparam int DW  = $clog2(MAX_WALK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TREE, S_ROOTW, S_RMOD, S_NRD, S_NODE,
    S_CUT, S_LEAFB, S_RRD, S_RULE, S_DONE
  } state_t;

  state_t          state_r;
  logic [4:0]      tc_r;
  logic [CW-1:0]   ntrees_r;
  logic [CW-1:0]   t_r;
  logic [DW-1:0]   d_r;
  logic            first_r;
  logic            abort_r;
  logic [15:0]     prio_r;
  logic [31:0]     sip_r;
  logic [31:0]     dip_r;
  logic [15:0]     sport_r;
  logic [15:0]     dport_r;
  logic [7:0]      proto_r;
  logic [AWN-1:0]  node_r;
  logic [AWR-1:0]  rule_r;
  logic [7:0]      cnt_r;
  logic [7:0]      j_r;
  logic            out_valid_r;
  pdtc_pkg::out_item_t out_data_r;

  // memory ports
  logic [63:0]     nmask_q;
  logic [38:0]     ninfo_q;
  logic [63:0]     rsrc_q;
  logic [63:0]     rdst_q;
  logic [63:0]     rport_q;
  logic [31:0]     rpp_q;
  logic [11:0]     root_q;
  logic            node_re;
  logic            rule_re;
  logic            root_re;
  logic            wr;

  // extract units
  pdtc_pkg::ext_req_t nreq;
  pdtc_pkg::ext_req_t rreq;
  logic               ndone;
  logic               rdone;
  logic [AWN-1:0]     nres;
  logic [AWR-1:0]     rres;

  // node info fields
  logic [1:0]  kind;
  logic [11:0] base;
  logic [7:0]  lcnt;
  logic [15:0] maxp;
  logic [15:0] rprio;
  logic        hit;

  assign kind  = ninfo_q[1:0];
  assign base  = ninfo_q[14:3];
  assign maxp  = ninfo_q[38:23];
  assign lcnt  = (kind == pdtc_pkg::KIND_LEAF) ? ninfo_q[22:15] : 8'd0;
  assign rprio = rpp_q[31:16];

  // five range checks of one rule
  assign hit = (sip_r >= rsrc_q[31:0]) && (sip_r <= rsrc_q[63:32]) &&
               (dip_r >= rdst_q[31:0]) && (dip_r <= rdst_q[63:32]) &&
               (sport_r >= rport_q[15:0]) && (sport_r <= rport_q[31:16]) &&
               (dport_r >= rport_q[47:32]) && (dport_r <= rport_q[63:48]) &&
               (proto_r >= rpp_q[7:0]) && (proto_r <= rpp_q[15:8]);

  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign wr        = cmd_pop && (cmd.op != pdtc_pkg::OP_LOOKUP);
  assign node_re   = (state_r == S_NRD);
  assign rule_re   = (state_r == S_RRD);
  assign root_re   = (state_r == S_TREE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // node memories
  pdtc_ram #(.WIDTH(64), .DEPTH(NODE_DEPTH)) u_nmask (
    .clk(clk), .we(wr && cmd.op == pdtc_pkg::OP_NODE_MASK), .waddr(AWN'(cmd.index)),
    .wdata(cmd.data), .re(node_re), .raddr(node_r), .rdata(nmask_q)
  );
  pdtc_ram #(.WIDTH(39), .DEPTH(NODE_DEPTH)) u_ninfo (
    .clk(clk), .we(wr && cmd.op == pdtc_pkg::OP_NODE_INFO), .waddr(AWN'(cmd.index)),
    .wdata(cmd.data[38:0]), .re(node_re), .raddr(node_r), .rdata(ninfo_q)
  );

  // rule memories
  pdtc_ram #(.WIDTH(64), .DEPTH(RULE_DEPTH)) u_rsrc (
    .clk(clk), .we(wr && cmd.op == pdtc_pkg::OP_RULE_SRC), .waddr(AWR'(cmd.index)),
    .wdata(cmd.data), .re(rule_re), .raddr(rule_r), .rdata(rsrc_q)
  );
  pdtc_ram #(.WIDTH(64), .DEPTH(RULE_DEPTH)) u_rdst (
    .clk(clk), .we(wr && cmd.op == pdtc_pkg::OP_RULE_DST), .waddr(AWR'(cmd.index)),
    .wdata(cmd.data), .re(rule_re), .raddr(rule_r), .rdata(rdst_q)
  );
  pdtc_ram #(.WIDTH(64), .DEPTH(RULE_DEPTH)) u_rport (
    .clk(clk), .we(wr && cmd.op == pdtc_pkg::OP_RULE_PORT), .waddr(AWR'(cmd.index)),
    .wdata(cmd.data), .re(rule_re), .raddr(rule_r), .rdata(rport_q)
  );
  pdtc_ram #(.WIDTH(32), .DEPTH(RULE_DEPTH)) u_rpp (
    .clk(clk), .we(wr && cmd.op == pdtc_pkg::OP_RULE_PPRIO), .waddr(AWR'(cmd.index)),
    .wdata(cmd.data[31:0]), .re(rule_re), .raddr(rule_r), .rdata(rpp_q)
  );

  // root table
  pdtc_ram #(.WIDTH(12), .DEPTH(MAX_TREES)) u_root (
    .clk(clk), .we(wr && cmd.op == pdtc_pkg::OP_ROOT), .waddr(TW'(cmd.index)),
    .wdata(cmd.data[11:0]), .re(root_re), .raddr(TW'(t_r)), .rdata(root_q)
  );

  // child index and root reduction modulo the node depth
  always_comb begin
    nreq.start = 1'b0;
    nreq.base  = root_q;
    nreq.value = 64'd0;
    nreq.mask  = 64'd0;
    nreq.steps = pdtc_pkg::STEPS_NONE;
    if (state_r == S_ROOTW) begin
      nreq.start = 1'b1;
    end else if (state_r == S_NODE) begin
      nreq.base = base;
      if (kind == pdtc_pkg::KIND_ADDR_CUT) begin
        nreq.value = {dip_r, sip_r};
        nreq.mask  = nmask_q;
        nreq.steps = pdtc_pkg::STEPS_ADDR;
      end else begin
        nreq.value = 64'(ninfo_q[2] ? dport_r : sport_r);
        nreq.mask  = 64'(nmask_q[15:0]);
        nreq.steps = pdtc_pkg::STEPS_PORT;
      end
      nreq.start = (prio_r < maxp) && (first_r || d_r != DW'(MAX_WALK_DEPTH)) &&
                   (kind == pdtc_pkg::KIND_ADDR_CUT || kind == pdtc_pkg::KIND_PORT_CUT);
    end
  end

  // leaf base modulo the rule depth
  always_comb begin
    rreq.start = (state_r == S_NODE) && (prio_r < maxp) &&
                 (first_r || d_r != DW'(MAX_WALK_DEPTH)) &&
                 !(kind == pdtc_pkg::KIND_ADDR_CUT || kind == pdtc_pkg::KIND_PORT_CUT) &&
                 (lcnt != 8'd0);
    rreq.base  = base;
    rreq.value = 64'd0;
    rreq.mask  = 64'd0;
    rreq.steps = pdtc_pkg::STEPS_NONE;
  end

  pdtc_extract #(.MOD(NODE_DEPTH)) u_next (
    .clk(clk), .rst_n(rst_n), .req(nreq), .done(ndone), .result(nres)
  );
  pdtc_extract #(.MOD(RULE_DEPTH)) u_rext (
    .clk(clk), .rst_n(rst_n), .req(rreq), .done(rdone), .result(rres)
  );

  // walk sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tc_r        <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tc_r <= cfg_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_pop && cmd.op == pdtc_pkg::OP_LOOKUP) begin
            sip_r    <= cmd.src_ip;
            dip_r    <= cmd.dst_ip;
            sport_r  <= cmd.src_port;
            dport_r  <= cmd.dst_port;
            proto_r  <= cmd.protocol;
            prio_r   <= cmd.floor_priority;
            abort_r  <= 1'b0;
            t_r      <= '0;
            ntrees_r <= (7'(tc_r) > 7'(MAX_TREES)) ? CW'(MAX_TREES) : CW'(tc_r);
            state_r  <= S_TREE;
          end
        end
        S_TREE: begin
          state_r <= (t_r < ntrees_r) ? S_ROOTW : S_DONE;
        end
        S_ROOTW: begin
          first_r <= 1'b1;
          d_r     <= '0;
          state_r <= S_RMOD;
        end
        S_RMOD: begin
          if (ndone) begin
            node_r  <= nres;
            state_r <= S_NRD;
          end
        end
        S_NRD: begin
          state_r <= S_NODE;
        end
        S_NODE: begin
          first_r <= 1'b0;
          cnt_r   <= lcnt;
          j_r     <= 8'd0;
          if (prio_r >= maxp) begin
            if (first_r) begin
              state_r <= S_DONE;
            end else begin
              t_r     <= t_r + CW'(1);
              state_r <= S_TREE;
            end
          end else if (!first_r && d_r == DW'(MAX_WALK_DEPTH)) begin
            abort_r <= 1'b1;
            t_r     <= t_r + CW'(1);
            state_r <= S_TREE;
          end else if (nreq.start) begin
            state_r <= S_CUT;
          end else if (rreq.start) begin
            state_r <= S_LEAFB;
          end else begin
            t_r     <= t_r + CW'(1);
            state_r <= S_TREE;
          end
        end
        S_CUT: begin
          if (ndone) begin
            node_r  <= nres;
            d_r     <= d_r + DW'(1);
            state_r <= S_NRD;
          end
        end
        S_LEAFB: begin
          if (rdone) begin
            rule_r  <= rres;
            state_r <= S_RRD;
          end
        end
        S_RRD: begin
          state_r <= S_RULE;
        end
        S_RULE: begin
          if (prio_r >= rprio || hit || (j_r + 8'd1) == cnt_r) begin
            if (prio_r < rprio && hit) begin
              prio_r <= rprio;
            end
            t_r     <= t_r + CW'(1);
            state_r <= S_TREE;
          end else begin
            j_r     <= j_r + 8'd1;
            rule_r  <= (rule_r == AWR'(RULE_DEPTH - 1)) ? '0 : rule_r + AWR'(1);
            state_r <= S_RRD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r              <= 1'b1;
            out_data_r.best_priority <= prio_r;
            out_data_r.walk_aborted  <= abort_r;
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // walk depth never passes the limit
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NODE) |-> (d_r <= DW'(MAX_WALK_DEPTH)))
    else $error("walk depth beyond limit");

  // extract results arrive only while the sequencer waits for them
  a_ndone: assert property (@(posedge clk) disable iff (!rst_n)
    ndone |-> (state_r == S_RMOD || state_r == S_CUT))
    else $error("node extract result while not waiting");

  a_rdone: assert property (@(posedge clk) disable iff (!rst_n)
    rdone |-> (state_r == S_LEAFB))
    else $error("rule extract result while not waiting");

  // a result is never overwritten before it is taken
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result lost");
`endif

endmodule

// ===== hw/rtl/pext_decision_tree_classifier_lookup.sv =====
// ----------------------------------------------------------------------------
// pext_decision_tree_classifier_lookup
// five-tuple packet classifier over software-built cut trees
// ----------------------------------------------------------------------------
//  channel   ports                          direction
//  input     in_valid / in_ready / in_data   transactions in (lookups, writes)
//  result    out_valid / out_ready / out_data  one result per lookup
//  config    cfg_we / cfg_data              tree count, written at once
//
//  a write is done as the engine pops it; a lookup walks the trees in turn:
//  root read and reduction, then per node a registered read and a child
//  extract by the serial extract unit (4 mask bits a cycle) at a cut, or a
//  leaf base reduction and rule scan at a leaf. no clearing pass after
//  reset; memories hold garbage until written. while the engine walks or
//  a result waits on out_ready, the front and the two-entry queue fill up.
// ----------------------------------------------------------------------------
module pext_decision_tree_classifier_lookup #(
  parameter int NODE_DEPTH     = pdtc_pkg::NodeDepthDef,
  parameter int RULE_DEPTH     = pdtc_pkg::RuleDepthDef,
  parameter int MAX_TREES      = pdtc_pkg::MaxTreesDef,
  parameter int MAX_WALK_DEPTH = pdtc_pkg::MaxWalkDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdtc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pdtc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data
);

  logic           q_push;
  logic           q_push_ready;
  pdtc_pkg::cmd_t q_push_data;
  logic           q_valid;
  logic           q_pop;
  pdtc_pkg::cmd_t q_data;

  // decode front
  pdtc_front #(
    .NODE_DEPTH(NODE_DEPTH), .RULE_DEPTH(RULE_DEPTH), .MAX_TREES(MAX_TREES)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .push(q_push), .push_ready(q_push_ready),
    .push_data(q_push_data)
  );

  // command queue
  pdtc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_ready(q_push_ready),
    .push_data(q_push_data), .pop_valid(q_valid), .pop(q_pop), .pop_data(q_data)
  );

  // walk engine
  pdtc_engine #(
    .NODE_DEPTH(NODE_DEPTH), .RULE_DEPTH(RULE_DEPTH),
    .MAX_TREES(MAX_TREES), .MAX_WALK_DEPTH(MAX_WALK_DEPTH)
  ) u_engine (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cmd_valid(q_valid), .cmd_pop(q_pop), .cmd(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
